[rtl/core/mpe_pkg.sv]
// Shared types and constants for the matrix polynomial evaluator.
package mpe_pkg;

  // Width of one matrix element, coefficient or result element.
  localparam int unsigned ELEM_W = 32;

  // Function codes carried by an input transfer.
  typedef enum logic [1:0] {
    FUNC_LOAD_ELEM  = 2'd0,
    FUNC_LOAD_COEF  = 2'd1,
    FUNC_START      = 2'd2,
    FUNC_UNUSED     = 2'd3
  } func_t;

  // Configuration register indexes.
  localparam logic CFG_SIZE   = 1'b0;
  localparam logic CFG_DEGREE = 1'b1;

  // Control of the shared multiply unit.
  typedef struct packed {
    logic mul_en;    // capture a new product
    logic frac_shift; // floor the product back to fixed point
  } arith_ctl_t;

endpackage

[rtl/core/matrix_polynomial_eval.sv]
// Top level of the matrix polynomial evaluator: sequencer, config and result register.
//
// Usage: the input channel (in_valid/in_stall) carries func, index and value.
// A func of zero loads one matrix element at a row-major index, a func of one
// loads an integer coefficient and a func of two starts p(A). cfg_we writes
// size_in_use (index 0) or degree (index 1); write them only while the block is
// idle, which the block itself does not enforce. A start with size N and degree d
// runs on one shared multiplier: a set-up, d scaled powers added into the sum and
// max(d-1,0) matrix products, each multiply-accumulate being a memory read, a
// multiply, then saturate and accumulate. The N*N results then leave on the
// result channel (out_valid/out_stall), row-major, with out_last on the final
// one; each result is read only after the one before it is taken. in_stall
// stays high from the start transfer until the last result transfer. A stalled
// result holds its value until taken. Reset clears the sequencer, the saturation
// flag and the registers (size 8, degree 0); the memories keep no reset value
// and must be loaded before use.
module matrix_polynomial_eval #(
  parameter int unsigned MAX_SIZE   = 8,
  parameter int unsigned MAX_DEGREE = 15,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_func,
  input  logic [5:0]                        in_index,
  input  logic signed [mpe_pkg::ELEM_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_row,
  output logic [2:0]                        out_col,
  output logic signed [mpe_pkg::ELEM_W-1:0] out_element,
  output logic                              out_last,
  output logic                              out_saturated,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [3:0]                        cfg_wdata
);
  import mpe_pkg::*;

  localparam int unsigned CELLS = MAX_SIZE * MAX_SIZE;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned NCOEF = MAX_DEGREE + 1;
  localparam int unsigned DW    = (NCOEF > 1) ? $clog2(NCOEF) : 1;

  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_DIAG_RD  = 15'b000000000000010,
    ST_DIAG_MUL = 15'b000000000000100,
    ST_DIAG_SAT = 15'b000000000001000,
    ST_COPY_RD  = 15'b000000000010000,
    ST_COPY_WR  = 15'b000000000100000,
    ST_SC_RD    = 15'b000000001000000,
    ST_SC_MUL   = 15'b000000010000000,
    ST_SC_ADD   = 15'b000000100000000,
    ST_MM_RD    = 15'b000001000000000,
    ST_MM_MUL   = 15'b000010000000000,
    ST_MM_ACC   = 15'b000100000000000,
    ST_OUT_RD   = 15'b001000000000000,
    ST_OUT_LOAD = 15'b010000000000000,
    ST_OUT_WAIT = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0]               size_r, degree_r;
  logic [IW-1:0]            nm1_r, nm1_nxt;
  logic [3:0]               dg_r, dg_nxt;
  logic [3:0]               pw_r, pw_nxt;
  logic [IW-1:0]            row_r, row_nxt, col_r, col_nxt, k_r, k_nxt;
  logic                     bank_r, bank_nxt;
  logic                     flag_r, flag_nxt;
  logic signed [ELEM_W-1:0] diag_r, diag_nxt;
  logic signed [ELEM_W-1:0] acc_r, acc_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [2:0]               out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic signed [ELEM_W-1:0] out_elem_r, out_elem_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     in_xfer, out_xfer;
  logic                     col_end, cells_done;
  int                       n_int, sz_int, dg_int;
  logic [AW-1:0]            addr_rc, addr_rk, addr_kc;

  // Memory and arithmetic hookups.
  logic                     mat_we, coef_we, pow_we, sum_we;
  logic [AW-1:0]            mat_raddr;
  logic [DW-1:0]            coef_raddr;
  logic [AW:0]              pow_waddr, pow_raddr;
  logic signed [ELEM_W-1:0] pow_wdata, sum_wdata;
  logic signed [ELEM_W-1:0] mat_rdata, coef_rdata, pow_rdata, sum_rdata;
  arith_ctl_t               actl;
  logic signed [ELEM_W-1:0] op_a, op_b, add_a, prod_q, sum_q;
  logic                     prod_ovf, sum_ovf;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= 4'd8;
      degree_r <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIZE:   size_r   <= cfg_wdata;
        CFG_DEGREE: degree_r <= cfg_wdata;
        default:    size_r   <= size_r;
      endcase
    end
  end

  // Cell addresses for the current row, column and inner index.
  always_comb begin
    n_int   = int'(nm1_r) + 1;
    addr_rc = AW'(int'(row_r) * n_int + int'(col_r));
    addr_rk = AW'(int'(row_r) * n_int + int'(k_r));
    addr_kc = AW'(int'(k_r) * n_int + int'(col_r));
    col_end    = (col_r == nm1_r);
    cells_done = col_end && (row_r == nm1_r);
  end

  // Clamped size and degree taken at the start transfer.
  always_comb begin
    sz_int = int'(size_r);
    if (sz_int == 0) sz_int = 1;
    if (sz_int > int'(MAX_SIZE)) sz_int = int'(MAX_SIZE);
    dg_int = int'(degree_r);
    if (dg_int > int'(MAX_DEGREE)) dg_int = int'(MAX_DEGREE);
  end

  // Load writes into the operand memories.
  always_comb begin
    mat_we  = in_xfer && (func_t'(in_func) == FUNC_LOAD_ELEM)
              && (32'(in_index) < 32'(CELLS));
    coef_we = in_xfer && (func_t'(in_func) == FUNC_LOAD_COEF)
              && (32'(in_index) <= 32'(MAX_DEGREE));
  end

  // Read addresses follow the state and the counters.
  always_comb begin
    mat_raddr  = (state_r == ST_MM_RD) ? addr_kc : addr_rc;
    coef_raddr = (state_r == ST_DIAG_RD) ? DW'(0) : DW'(int'(pw_r));
    pow_raddr  = {bank_r, (state_r == ST_MM_RD) ? addr_rk : addr_rc};
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    nm1_nxt       = nm1_r;
    dg_nxt        = dg_r;
    pw_nxt        = pw_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    k_nxt         = k_r;
    bank_nxt      = bank_r;
    flag_nxt      = flag_r;
    diag_nxt      = diag_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_elem_nxt  = out_elem_r;
    out_last_nxt  = out_last_r;
    pow_we        = 1'b0;
    pow_waddr     = {bank_r, addr_rc};
    pow_wdata     = mat_rdata;
    sum_we        = 1'b0;
    sum_wdata     = sum_q;
    actl          = '0;
    op_a          = coef_rdata;
    op_b          = pow_rdata;
    add_a         = sum_rdata;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (func_t'(in_func) == FUNC_START)) begin
          nm1_nxt   = IW'(sz_int - 1);
          dg_nxt    = 4'(dg_int);
          flag_nxt  = 1'b0;
          row_nxt   = '0;
          col_nxt   = '0;
          k_nxt     = '0;
          bank_nxt  = 1'b0;
          pw_nxt    = 4'd1;
          state_nxt = ST_DIAG_RD;
        end
      end
      ST_DIAG_RD: begin
        state_nxt = ST_DIAG_MUL;
      end
      ST_DIAG_MUL: begin
        // c0 times one in fixed point, using the shared multiplier.
        actl.mul_en = 1'b1;
        op_b        = ELEM_W'(64'd1 << FRAC_BITS);
        state_nxt   = ST_DIAG_SAT;
      end
      ST_DIAG_SAT: begin
        diag_nxt  = prod_q;
        flag_nxt  = flag_r | prod_ovf;
        state_nxt = ST_COPY_RD;
      end
      ST_COPY_RD: begin
        state_nxt = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        // Seed the first power with A and the sum with c0 on the diagonal.
        pow_we    = 1'b1;
        sum_we    = 1'b1;
        sum_wdata = (row_r == col_r) ? diag_r : '0;
        col_nxt   = col_end ? '0 : col_r + 1'b1;
        row_nxt   = col_end ? row_r + 1'b1 : row_r;
        if (cells_done) begin
          row_nxt   = '0;
          state_nxt = (dg_r == 4'd0) ? ST_OUT_RD : ST_SC_RD;
        end else begin
          state_nxt = ST_COPY_RD;
        end
      end
      ST_SC_RD: begin
        state_nxt = ST_SC_MUL;
      end
      ST_SC_MUL: begin
        actl.mul_en = 1'b1;
        state_nxt   = ST_SC_ADD;
      end
      ST_SC_ADD: begin
        sum_we   = 1'b1;
        flag_nxt = flag_r | prod_ovf | sum_ovf;
        col_nxt  = col_end ? '0 : col_r + 1'b1;
        row_nxt  = col_end ? row_r + 1'b1 : row_r;
        if (cells_done) begin
          row_nxt = '0;
          if (pw_r == dg_r) begin
            state_nxt = ST_OUT_RD;
          end else begin
            pw_nxt    = pw_r + 4'd1;
            acc_nxt   = '0;
            k_nxt     = '0;
            state_nxt = ST_MM_RD;
          end
        end else begin
          state_nxt = ST_SC_RD;
        end
      end
      ST_MM_RD: begin
        state_nxt = ST_MM_MUL;
      end
      ST_MM_MUL: begin
        actl.mul_en     = 1'b1;
        actl.frac_shift = 1'b1;
        op_a            = pow_rdata;
        op_b            = mat_rdata;
        state_nxt       = ST_MM_ACC;
      end
      ST_MM_ACC: begin
        // Accumulate one term; on the last term write into the other bank.
        add_a     = acc_r;
        acc_nxt   = sum_q;
        flag_nxt  = flag_r | prod_ovf | sum_ovf;
        state_nxt = ST_MM_RD;
        if (k_r == nm1_r) begin
          pow_we    = 1'b1;
          pow_waddr = {~bank_r, addr_rc};
          pow_wdata = sum_q;
          acc_nxt   = '0;
          k_nxt     = '0;
          col_nxt   = col_end ? '0 : col_r + 1'b1;
          row_nxt   = col_end ? row_r + 1'b1 : row_r;
          if (cells_done) begin
            row_nxt   = '0;
            bank_nxt  = ~bank_r;
            state_nxt = ST_SC_RD;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_OUT_RD: begin
        state_nxt = ST_OUT_LOAD;
      end
      ST_OUT_LOAD: begin
        out_valid_nxt = 1'b1;
        out_row_nxt   = 3'(row_r);
        out_col_nxt   = 3'(col_r);
        out_elem_nxt  = sum_rdata;
        out_last_nxt  = cells_done;
        state_nxt     = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (out_xfer) begin
          out_valid_nxt = 1'b0;
          col_nxt       = col_end ? '0 : col_r + 1'b1;
          row_nxt       = col_end ? row_r + 1'b1 : row_r;
          state_nxt     = out_last_r ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Counters and data registers.
  always_ff @(posedge clk) begin
    nm1_r      <= nm1_nxt;
    dg_r       <= dg_nxt;
    pw_r       <= pw_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    k_r        <= k_nxt;
    bank_r     <= bank_nxt;
    diag_r     <= diag_nxt;
    acc_r      <= acc_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_elem_r <= out_elem_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_element   = out_elem_r;
  assign out_last      = out_last_r;
  assign out_saturated = flag_r;

  mpe_operands #(
    .CELLS(CELLS), .AW(AW), .NCOEF(NCOEF), .DW(DW)
  ) u_operands (
    .clk        (clk),
    .mat_we     (mat_we),
    .mat_waddr  (AW'(in_index)),
    .coef_we    (coef_we),
    .coef_waddr (DW'(in_index)),
    .wdata      (in_value),
    .mat_raddr  (mat_raddr),
    .coef_raddr (coef_raddr),
    .mat_rdata  (mat_rdata),
    .coef_rdata (coef_rdata)
  );

  mpe_work #(
    .CELLS(CELLS), .AW(AW)
  ) u_work (
    .clk       (clk),
    .pow_we    (pow_we),
    .pow_waddr (pow_waddr),
    .pow_wdata (pow_wdata),
    .pow_raddr (pow_raddr),
    .pow_rdata (pow_rdata),
    .sum_we    (sum_we),
    .sum_addr  (addr_rc),
    .sum_wdata (sum_wdata),
    .sum_rdata (sum_rdata)
  );

  mpe_arith #(
    .FRAC_BITS(FRAC_BITS)
  ) u_arith (
    .clk      (clk),
    .ctl      (actl),
    .op_a     (op_a),
    .op_b     (op_b),
    .add_a    (add_a),
    .prod_q   (prod_q),
    .prod_ovf (prod_ovf),
    .sum_q    (sum_q),
    .sum_ovf  (sum_ovf)
  );

endmodule

[rtl/core/mpe_arith.sv]
// Shared multiplier with fixed-point truncation, saturation and a saturating adder.
module mpe_arith #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk,
  input  mpe_pkg::arith_ctl_t             ctl,
  input  logic signed [mpe_pkg::ELEM_W-1:0] op_a,
  input  logic signed [mpe_pkg::ELEM_W-1:0] op_b,
  input  logic signed [mpe_pkg::ELEM_W-1:0] add_a,
  output logic signed [mpe_pkg::ELEM_W-1:0] prod_q,
  output logic                            prod_ovf,
  output logic signed [mpe_pkg::ELEM_W-1:0] sum_q,
  output logic                            sum_ovf
);
  import mpe_pkg::*;

  localparam int unsigned PW = 2 * ELEM_W;

  logic signed [PW-1:0]     product_r;
  logic                     shift_r;
  logic signed [PW-1:0]     scaled;
  logic signed [ELEM_W:0]   wide_sum;

  // Product register: one full-width signed multiply per cycle while mul_en is set.
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      product_r <= PW'(op_a) * PW'(op_b);
      shift_r   <= ctl.frac_shift;
    end
  end

  // When the shift is selected, an arithmetic shift floors towards minus infinity; then clamp to 32 bits.
  always_comb begin
    scaled = shift_r ? (product_r >>> FRAC_BITS) : product_r;
    if (scaled > PW'(signed'({1'b0, {(ELEM_W-1){1'b1}}}))) begin
      prod_q   = {1'b0, {(ELEM_W-1){1'b1}}};
      prod_ovf = 1'b1;
    end else if (scaled < PW'(signed'({1'b1, {(ELEM_W-1){1'b0}}}))) begin
      prod_q   = {1'b1, {(ELEM_W-1){1'b0}}};
      prod_ovf = 1'b1;
    end else begin
      prod_q   = scaled[ELEM_W-1:0];
      prod_ovf = 1'b0;
    end
  end

  // Saturating add of the clamped product to the running value.
  always_comb begin
    wide_sum = {add_a[ELEM_W-1], add_a} + {prod_q[ELEM_W-1], prod_q};
    if (wide_sum[ELEM_W] != wide_sum[ELEM_W-1]) begin
      sum_ovf = 1'b1;
      sum_q   = wide_sum[ELEM_W] ? {1'b1, {(ELEM_W-1){1'b0}}}
                                 : {1'b0, {(ELEM_W-1){1'b1}}};
    end else begin
      sum_ovf = 1'b0;
      sum_q   = wide_sum[ELEM_W-1:0];
    end
  end

endmodule

[rtl/core/mpe_operands.sv]
// Operand memories: the input matrix and the coefficient list.
module mpe_operands #(
  parameter int unsigned CELLS = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned NCOEF = 16,
  parameter int unsigned DW    = 4
) (
  input  logic                              clk,
  input  logic                              mat_we,
  input  logic [AW-1:0]                     mat_waddr,
  input  logic                              coef_we,
  input  logic [DW-1:0]                     coef_waddr,
  input  logic signed [mpe_pkg::ELEM_W-1:0] wdata,
  input  logic [AW-1:0]                     mat_raddr,
  input  logic [DW-1:0]                     coef_raddr,
  output logic signed [mpe_pkg::ELEM_W-1:0] mat_rdata,
  output logic signed [mpe_pkg::ELEM_W-1:0] coef_rdata
);
  import mpe_pkg::*;

  logic signed [ELEM_W-1:0] mat_mem [CELLS];
  logic signed [ELEM_W-1:0] coef_mem [NCOEF];

  // Matrix memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= wdata;
    end
    mat_rdata <= mat_mem[mat_raddr];
  end

  // Coefficient memory.
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= wdata;
    end
    coef_rdata <= coef_mem[coef_raddr];
  end

endmodule

[rtl/core/mpe_work.sv]
// Working memories: two banks of matrix powers and the running sum.
module mpe_work #(
  parameter int unsigned CELLS = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                              clk,
  input  logic                              pow_we,
  input  logic [AW:0]                       pow_waddr,
  input  logic signed [mpe_pkg::ELEM_W-1:0] pow_wdata,
  input  logic [AW:0]                       pow_raddr,
  output logic signed [mpe_pkg::ELEM_W-1:0] pow_rdata,
  input  logic                              sum_we,
  input  logic [AW-1:0]                     sum_addr,
  input  logic signed [mpe_pkg::ELEM_W-1:0] sum_wdata,
  output logic signed [mpe_pkg::ELEM_W-1:0] sum_rdata
);
  import mpe_pkg::*;

  logic signed [ELEM_W-1:0] pow_mem [2*CELLS];
  logic signed [ELEM_W-1:0] sum_mem [CELLS];

  // Power memory: the bank bit is the top address bit.
  always_ff @(posedge clk) begin
    if (pow_we) begin
      pow_mem[pow_waddr] <= pow_wdata;
    end
    pow_rdata <= pow_mem[pow_raddr];
  end

  // Sum memory: read-before-write on a shared address.
  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_addr] <= sum_wdata;
    end
    sum_rdata <= sum_mem[sum_addr];
  end

endmodule

[rtl/core/mpe_checker.sv]
// Port-level checks for the matrix polynomial evaluator, bound to the top level.
module mpe_port_props (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_last
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // No input is taken while a result is pending.
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input ready while a result is pending");

  // After the final result leaves, no further result follows at once and input is accepted again.
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !out_stall |=> !out_valid && !in_stall)
    else $error("block not idle after the last result");

  // Reset empties the result channel.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind matrix_polynomial_eval mpe_port_props u_mpe_port_props (.*);
